### hdl/sasw_pkg.sv
// Shared types, codes and helpers for the selective-ack send window.
// Used by the slot lanes, ring rotator, slide scanner and top level.
package sasw_pkg;

   localparam int OP_W           = 2;
   localparam int SEQ_PORT_W     = 16;
   localparam int MASK_W         = 64;
   localparam int SHIFT_W        = 7;
   localparam int STATUS_W       = 3;
   localparam int SLOT_PORT_W    = 6;
   localparam int WSIZE_W        = 7;
   localparam int WSIZE_RESET    = 64;
   localparam int MAX_WINDOW_DEF = 64;
   localparam int SEQ_BITS_DEF   = 16;

   typedef enum logic [OP_W-1:0] {
      OP_ENQUEUE  = 2'd0,
      OP_ACK_ONE  = 2'd1,
      OP_ACK_MASK = 2'd2,
      OP_CLEAR    = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 3'd0,
      STAT_SLID    = 3'd1,
      STAT_FULL    = 3'd2,
      STAT_INVALID = 3'd3,
      STAT_STALE   = 3'd4,
      STAT_GAP     = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      SLOT_FREE  = 2'd0,
      SLOT_DATA  = 2'd1,
      SLOT_ACKED = 2'd2
   } slot_type;

   // broadcast command to every slot lane
   typedef struct packed {
      logic clear;
      logic enqueue;
      logic ack;
      logic retire;
   } lane_ctl_type;

   // ones in bits below count; count of 64 gives all ones
   function automatic logic [MASK_W-1:0] low_mask(input logic [SHIFT_W-1:0] count);
      low_mask = ~({MASK_W{1'b1}} << count);
   endfunction

endpackage

### hdl/sasw_slot_lane.sv
// One ring slot of the send window: holds free / data / acked state.
// Depends on sasw_pkg for the slot codes and the lane command struct.
module sasw_slot_lane (
   input  logic                   clock,
   input  logic                   reset,
   input  sasw_pkg::lane_ctl_type lane_ctl,
   input  logic                   lane_sel,
   output sasw_pkg::slot_type     slot_state
);
   import sasw_pkg::*;

   slot_type state_ff;
   slot_type state_in;

   // apply the broadcast command: clear to every lane, the others where this lane is selected
   always_comb begin
      state_in = state_ff;
      if (lane_ctl.clear) begin
         state_in = SLOT_FREE;
      end else if (lane_sel && lane_ctl.enqueue) begin
         state_in = SLOT_DATA;
      end else if (lane_sel && lane_ctl.ack && (state_ff == SLOT_DATA)) begin
         state_in = SLOT_ACKED;
      end else if (lane_sel && lane_ctl.retire && (state_ff == SLOT_ACKED)) begin
         state_in = SLOT_FREE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SLOT_FREE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign slot_state = state_ff;

endmodule

### hdl/sasw_ring_rotate.sv
// Maps a vector indexed by offset from the window base onto ring positions,
// wrapping modulo the active window. Depends on sasw_pkg.
module sasw_ring_rotate #(
   parameter int MAX_WINDOW = sasw_pkg::MAX_WINDOW_DEF
) (
   input  logic [sasw_pkg::MASK_W-1:0]      offset_vec,
   input  logic [$clog2(MAX_WINDOW)-1:0]    base_pos,
   input  logic [$clog2(MAX_WINDOW+1)-1:0]  window,
   output logic [MAX_WINDOW-1:0]            ring_vec
);
   import sasw_pkg::*;

   localparam int CNT_W = $clog2(MAX_WINDOW + 1);

   logic [CNT_W-1:0]  wrap_shift;
   logic [MASK_W-1:0] rotated;

   // offsets past the ring end wrap to the low positions
   assign wrap_shift = window - CNT_W'(base_pos);
   assign rotated    = ((offset_vec << base_pos) | (offset_vec >> wrap_shift))
                       & low_mask(SHIFT_W'(window));
   assign ring_vec   = rotated[MAX_WINDOW-1:0];

endmodule

### hdl/sasw_slide_scan.sv
// Merge stage: counts acked slots in ring order from the base position,
// wrapping at the window, and registers the run length. Depends on sasw_pkg.
module sasw_slide_scan #(
   parameter int MAX_WINDOW = sasw_pkg::MAX_WINDOW_DEF
) (
   input  logic                             clock,
   input  logic [MAX_WINDOW-1:0]            acked_vec,
   input  logic [$clog2(MAX_WINDOW)-1:0]    base_pos,
   input  logic [$clog2(MAX_WINDOW+1)-1:0]  window,
   output logic [$clog2(MAX_WINDOW+1)-1:0]  run_len
);
   import sasw_pkg::*;

   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int EXT_W = MAX_WINDOW + 1;

   // index of the lowest clear bit; the top bit is always clear
   function automatic logic [CNT_W-1:0] first_zero(input logic [EXT_W-1:0] vec);
      logic [EXT_W-1:0] one_hot;
      logic [CNT_W-1:0] idx;
      one_hot = ~vec & (vec + EXT_W'(1));
      idx     = '0;
      for (int i = 0; i < EXT_W; i++) begin
         if (one_hot[i]) begin
            idx = idx | CNT_W'(i);
         end
      end
      return idx;
   endfunction

   logic [MASK_W-1:0] below_base;
   logic [EXT_W-1:0]  upper_vec;
   logic [EXT_W-1:0]  whole_vec;
   logic [CNT_W-1:0]  upper_zero;
   logic [CNT_W-1:0]  whole_zero;
   logic [CNT_W-1:0]  base_cnt;
   logic [CNT_W-1:0]  run_len_in;
   logic [CNT_W-1:0]  run_len_ff;

   assign base_cnt   = CNT_W'(base_pos);
   assign below_base = low_mask(SHIFT_W'(base_pos));
   assign upper_vec  = {1'b0, acked_vec | below_base[MAX_WINDOW-1:0]};
   assign whole_vec  = {1'b0, acked_vec};
   assign upper_zero = first_zero(upper_vec);
   assign whole_zero = first_zero(whole_vec);

   // run ends before the ring end, or wraps and continues from position zero
   always_comb begin
      if (upper_zero < window) begin
         run_len_in = upper_zero - base_cnt;
      end else if (whole_zero < base_cnt) begin
         run_len_in = window - base_cnt + whole_zero;
      end else begin
         run_len_in = window;
      end
   end

   always_ff @(posedge clock) begin
      run_len_ff <= run_len_in;
   end

   assign run_len = run_len_ff;

endmodule

### hdl/selective_ack_send_window.sv
// Selective-ack send window: sequence and ring-slot bookkeeping, one lane per slot.
// Acks that reach the lanes pass S_EXEC (decode+rotate), S_ACK (lane ack+scan) and
// S_FREE (free+slide) before rsp_valid; enqueue, clear and rejected acks finish in S_EXEC.
// req_stall is high outside S_IDLE, so no new request is taken until the last is done. A
// window_size write stalls req_ while the base slot is reduced modulo the window in S_REDUCE.
// Reset (synchronous): all slots free, sequences and base slot zero, window_size 64.
module selective_ack_send_window #(
   parameter int MAX_WINDOW = sasw_pkg::MAX_WINDOW_DEF,
   parameter int SEQ_BITS   = sasw_pkg::SEQ_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sasw_pkg::OP_W-1:0]           req_operation,
   input  logic [sasw_pkg::SEQ_PORT_W-1:0]     req_sequence_req,
   input  logic [sasw_pkg::MASK_W-1:0]         req_ack_mask,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sasw_pkg::STATUS_W-1:0]       rsp_status,
   output logic [sasw_pkg::SEQ_PORT_W-1:0]     rsp_assigned_sequence,
   output logic [sasw_pkg::SLOT_PORT_W-1:0]    rsp_slot_index,
   output logic [sasw_pkg::MASK_W-1:0]         rsp_released_slots,
   output logic [sasw_pkg::SEQ_PORT_W-1:0]     rsp_base_sequence,
   output logic [sasw_pkg::WSIZE_W-1:0]        rsp_free_space,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sasw_pkg::WSIZE_W-1:0]        csr_window_size
);
   import sasw_pkg::*;

   localparam int NW     = MAX_WINDOW;
   localparam int SLOT_W = $clog2(MAX_WINDOW);
   localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int DVS_W  = SLOT_W + CNT_W;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_REDUCE = 6'b000010,
      S_EXEC   = 6'b000100,
      S_ACK    = 6'b001000,
      S_FREE   = 6'b010000,
      S_WAIT   = 6'b100000
   } fsm_type;

   // saturate the register into 1..MAX_WINDOW
   function automatic logic [CNT_W-1:0] eff_window(input logic [WSIZE_W-1:0] size);
      if (size == '0) begin
         return CNT_W'(1);
      end else if (int'(size) > MAX_WINDOW) begin
         return CNT_W'(MAX_WINDOW);
      end else begin
         return CNT_W'(size);
      end
   endfunction

   function automatic logic [CNT_W-1:0] space_left(input logic [SEQ_BITS-1:0] head,
                                                   input logic [SEQ_BITS-1:0] base,
                                                   input logic [CNT_W-1:0]    window);
      logic [SEQ_BITS-1:0] in_use;
      in_use = head - base;
      if (in_use >= SEQ_BITS'(window)) begin
         return '0;
      end else begin
         return window - in_use[CNT_W-1:0];
      end
   endfunction

   // control state
   fsm_type              fsm_ff, fsm_in;
   logic [WSIZE_W-1:0]   window_size_ff, window_size_in;
   logic [SEQ_BITS-1:0]  base_seq_ff, base_seq_in;
   logic [SEQ_BITS-1:0]  head_seq_ff, head_seq_in;
   logic [SLOT_W-1:0]    raw_slot_ff, raw_slot_in;
   logic [SLOT_W-1:0]    base_pos_ff, base_pos_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [DVS_W-1:0]     dvs_ff, dvs_in;
   logic [CNT_W-1:0]     red_cnt_ff, red_cnt_in;
   op_type               op_ff, op_in;
   logic [SEQ_BITS-1:0]  req_ff, req_in;
   logic [MASK_W-1:0]    mask_ff, mask_in;
   logic [NW-1:0]        hit_ff, hit_in;
   status_type           res_status_ff, res_status_in;
   logic [SEQ_BITS-1:0]  res_assigned_ff, res_assigned_in;
   logic [SLOT_W-1:0]    res_slot_ff, res_slot_in;
   logic [NW-1:0]        res_released_ff, res_released_in;

   // output register
   status_type             rsp_status_ff;
   logic [SEQ_PORT_W-1:0]  rsp_assigned_ff;
   logic [SLOT_PORT_W-1:0] rsp_slot_ff;
   logic [MASK_W-1:0]      rsp_released_ff;
   logic [SEQ_PORT_W-1:0]  rsp_base_ff;
   logic [WSIZE_W-1:0]     rsp_free_ff;

   logic [CNT_W-1:0]     window;
   logic [SEQ_BITS-1:0]  used;
   logic                 full;
   logic [SUM_W-1:0]     enq_sum;
   logic [SLOT_W-1:0]    enq_pos;
   logic [NW-1:0]        enq_vec;
   logic [SEQ_BITS-1:0]  diff;
   logic [SEQ_BITS-1:0]  skip;
   logic                 behind;
   logic                 ahead;
   logic                 gap;
   logic [SHIFT_W-1:0]   lead_amt;
   logic [SHIFT_W-1:0]   skip_amt;
   logic [MASK_W-1:0]    offset_raw;
   logic [MASK_W-1:0]    offset_vec;
   logic [MASK_W-1:0]    window_mask;
   logic [NW-1:0]        win_vec;
   logic [MASK_W-1:0]    rot_in;
   logic [NW-1:0]        ring_vec;
   logic [CNT_W-1:0]     run_len;
   logic [SUM_W-1:0]     slide_sum;
   logic [SLOT_W-1:0]    slide_pos;
   logic [NW-1:0]        data_vec;
   logic [NW-1:0]        acked_vec;
   logic [NW-1:0]        scan_vec;
   slot_type             lane_state [NW];
   lane_ctl_type         lane_ctl;
   logic [NW-1:0]        lane_sel;
   logic                 idle;
   logic                 out_free;
   logic                 out_load;
   logic                 fin;

   assign window      = eff_window(window_size_ff);
   assign window_mask = low_mask(SHIFT_W'(window));
   assign win_vec     = window_mask[NW-1:0];
   assign idle        = (fsm_ff == S_IDLE);
   assign req_stall   = !idle || csr_valid;
   assign csr_ready   = idle;
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   // enqueue position: head offset from the base, wrapped once
   assign used    = head_seq_ff - base_seq_ff;
   assign full    = (used >= SEQ_BITS'(window));
   assign enq_sum = SUM_W'(base_pos_ff) + SUM_W'(used[CNT_W-1:0]);
   assign enq_pos = (enq_sum >= SUM_W'(window)) ? SLOT_W'(enq_sum - SUM_W'(window))
                                                 : SLOT_W'(enq_sum);
   assign enq_vec = NW'(1) << enq_pos;

   // ack decode: signed offset of the request from the window base
   assign diff     = req_ff - base_seq_ff;
   assign behind   = diff[SEQ_BITS-1];
   assign ahead    = !behind && (diff >= SEQ_BITS'(window));
   assign skip     = -diff;
   assign lead_amt = diff[SHIFT_W-1:0];
   assign skip_amt = skip[SHIFT_W-1:0];
   assign gap      = (skip > SEQ_BITS'(MASK_W)) || ((~mask_ff & low_mask(skip_amt)) != '0);

   // hits by offset from the base, trimmed to the window
   always_comb begin
      case (op_ff)
         OP_ACK_ONE: begin
            offset_raw = MASK_W'(1) << lead_amt;
         end
         OP_ACK_MASK: begin
            if (behind) begin
               offset_raw = mask_ff >> skip_amt;
            end else begin
               offset_raw = (mask_ff << lead_amt) | low_mask(lead_amt);
            end
         end
         default: begin
            offset_raw = '0;
         end
      endcase
   end

   assign offset_vec = offset_raw & window_mask;

   // shared rotator: ack hits while decoding, freed run while sliding
   assign rot_in = (fsm_ff == S_FREE) ? low_mask(SHIFT_W'(run_len)) : offset_vec;

   sasw_ring_rotate #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_rotate (
      .offset_vec (rot_in),
      .base_pos   (base_pos_ff),
      .window     (window),
      .ring_vec   (ring_vec)
   );

   // slot lanes
   for (genvar g = 0; g < NW; g++) begin : g_lane
      sasw_slot_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .lane_ctl   (lane_ctl),
         .lane_sel   (lane_sel[g]),
         .slot_state (lane_state[g])
      );
      assign data_vec[g]  = (lane_state[g] == SLOT_DATA);
      assign acked_vec[g] = (lane_state[g] == SLOT_ACKED);
   end

   // acked view after this cycle's hits land
   assign scan_vec = (acked_vec | (hit_ff & data_vec)) & win_vec;

   sasw_slide_scan #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_scan (
      .clock     (clock),
      .acked_vec (scan_vec),
      .base_pos  (base_pos_ff),
      .window    (window),
      .run_len   (run_len)
   );

   // new base position after freeing the run
   assign slide_sum = SUM_W'(base_pos_ff) + SUM_W'(run_len);
   assign slide_pos = (slide_sum >= SUM_W'(window)) ? SLOT_W'(slide_sum - SUM_W'(window))
                                                     : SLOT_W'(slide_sum);

   // sequencer
   always_comb begin
      fsm_in          = fsm_ff;
      window_size_in  = window_size_ff;
      base_seq_in     = base_seq_ff;
      head_seq_in     = head_seq_ff;
      raw_slot_in     = raw_slot_ff;
      base_pos_in     = base_pos_ff;
      dvs_in          = dvs_ff;
      red_cnt_in      = red_cnt_ff;
      op_in           = op_ff;
      req_in          = req_ff;
      mask_in         = mask_ff;
      hit_in          = hit_ff;
      res_status_in   = res_status_ff;
      res_assigned_in = res_assigned_ff;
      res_slot_in     = res_slot_ff;
      res_released_in = res_released_ff;
      lane_ctl        = '0;
      lane_sel        = '0;
      fin             = 1'b0;

      case (fsm_ff)
         S_IDLE: begin
            if (csr_valid) begin
               // take the new size, then reduce the base slot modulo it
               window_size_in = csr_window_size;
               base_pos_in    = raw_slot_ff;
               dvs_in         = DVS_W'(eff_window(csr_window_size)) << (SLOT_W - 1);
               red_cnt_in     = CNT_W'(SLOT_W);
               fsm_in         = S_REDUCE;
            end else if (req_valid) begin
               op_in   = op_type'(req_operation);
               req_in  = req_sequence_req[SEQ_BITS-1:0];
               mask_in = req_ack_mask;
               fsm_in  = S_EXEC;
            end
         end

         S_REDUCE: begin
            if (DVS_W'(base_pos_ff) >= dvs_ff) begin
               base_pos_in = base_pos_ff - SLOT_W'(dvs_ff);
            end
            dvs_in     = dvs_ff >> 1;
            red_cnt_in = red_cnt_ff - CNT_W'(1);
            if (red_cnt_ff == CNT_W'(1)) begin
               fsm_in = S_IDLE;
            end
         end

         S_EXEC: begin
            res_released_in = '0;
            res_assigned_in = '0;
            res_slot_in     = '0;
            res_status_in   = STAT_OK;
            case (op_ff)
               OP_ENQUEUE: begin
                  if (full) begin
                     res_status_in = STAT_FULL;
                  end else begin
                     res_assigned_in  = head_seq_ff;
                     res_slot_in      = enq_pos;
                     head_seq_in      = head_seq_ff + SEQ_BITS'(1);
                     lane_ctl.enqueue = 1'b1;
                     lane_sel         = enq_vec;
                  end
                  fin = 1'b1;
               end
               OP_CLEAR: begin
                  lane_ctl.clear = 1'b1;
                  base_seq_in    = '0;
                  head_seq_in    = '0;
                  raw_slot_in    = '0;
                  base_pos_in    = '0;
                  fin            = 1'b1;
               end
               OP_ACK_ONE, OP_ACK_MASK: begin
                  if (ahead) begin
                     res_status_in = STAT_INVALID;
                     fin           = 1'b1;
                  end else if (behind && (op_ff == OP_ACK_ONE)) begin
                     res_status_in = STAT_STALE;
                     fin           = 1'b1;
                  end else if (behind && gap) begin
                     res_status_in = STAT_GAP;
                     fin           = 1'b1;
                  end else begin
                     hit_in = ring_vec;
                     fsm_in = S_ACK;
                  end
               end
               default: begin
                  fin = 1'b1;
               end
            endcase
         end

         S_ACK: begin
            // mark hit data slots acked and record them as released
            lane_ctl.ack    = 1'b1;
            lane_sel        = hit_ff;
            res_released_in = hit_ff & data_vec;
            fsm_in          = S_FREE;
         end

         S_FREE: begin
            // free the acked run at the base and advance the window
            lane_ctl.retire = 1'b1;
            lane_sel        = ring_vec;
            base_seq_in     = base_seq_ff + SEQ_BITS'(run_len);
            if (run_len != '0) begin
               raw_slot_in   = slide_pos;
               base_pos_in   = slide_pos;
               res_status_in = STAT_SLID;
            end else begin
               res_status_in = STAT_OK;
            end
            fin = 1'b1;
         end

         S_WAIT: begin
            if (out_free) begin
               fsm_in = S_IDLE;
            end
         end

         default: begin
            fsm_in = S_IDLE;
         end
      endcase

      // hold the result when the output register is still occupied
      if (fin) begin
         fsm_in = out_free ? S_IDLE : S_WAIT;
      end
   end

   assign out_load     = (fin || (fsm_ff == S_WAIT)) && out_free;
   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff         <= S_IDLE;
         window_size_ff <= WSIZE_W'(WSIZE_RESET);
         base_seq_ff    <= '0;
         head_seq_ff    <= '0;
         raw_slot_ff    <= '0;
         base_pos_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         fsm_ff         <= fsm_in;
         window_size_ff <= window_size_in;
         base_seq_ff    <= base_seq_in;
         head_seq_ff    <= head_seq_in;
         raw_slot_ff    <= raw_slot_in;
         base_pos_ff    <= base_pos_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      dvs_ff          <= dvs_in;
      red_cnt_ff      <= red_cnt_in;
      op_ff           <= op_in;
      req_ff          <= req_in;
      mask_ff         <= mask_in;
      hit_ff          <= hit_in;
      res_status_ff   <= res_status_in;
      res_assigned_ff <= res_assigned_in;
      res_slot_ff     <= res_slot_in;
      res_released_ff <= res_released_in;
      if (out_load) begin
         rsp_status_ff   <= res_status_in;
         rsp_assigned_ff <= SEQ_PORT_W'(res_assigned_in);
         rsp_slot_ff     <= SLOT_PORT_W'(res_slot_in);
         rsp_released_ff <= MASK_W'(res_released_in);
         rsp_base_ff     <= SEQ_PORT_W'(base_seq_in);
         rsp_free_ff     <= WSIZE_W'(space_left(head_seq_in, base_seq_in, window));
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_assigned_sequence = rsp_assigned_ff;
   assign rsp_slot_index        = rsp_slot_ff;
   assign rsp_released_slots    = rsp_released_ff;
   assign rsp_base_sequence     = rsp_base_ff;
   assign rsp_free_space        = rsp_free_ff;

endmodule

### tb/sv/selective_ack_send_window_test.sv
// Self-checking testbench for the selective-ack send window: directed and random
// enqueue/ack/clear traffic over several window sizes, checked against a local model.
// Depends on sasw_pkg and the selective_ack_send_window top level.
module selective_ack_send_window_test;
   import sasw_pkg::*;

   localparam logic [MASK_W-1:0] ALL_ONES = '1;

   typedef struct {
      status_type              status;
      logic [SEQ_PORT_W-1:0]   assigned;
      logic [SLOT_PORT_W-1:0]  slot;
      logic [MASK_W-1:0]       released;
      logic [SEQ_PORT_W-1:0]   base;
      logic [WSIZE_W-1:0]      free;
   } window_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   op_type                  req_operation = OP_ENQUEUE;
   logic [SEQ_PORT_W-1:0]   req_sequence_req = '0;
   logic [MASK_W-1:0]       req_ack_mask = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [STATUS_W-1:0]     rsp_status;
   logic [SEQ_PORT_W-1:0]   rsp_assigned_sequence;
   logic [SLOT_PORT_W-1:0]  rsp_slot_index;
   logic [MASK_W-1:0]       rsp_released_slots;
   logic [SEQ_PORT_W-1:0]   rsp_base_sequence;
   logic [WSIZE_W-1:0]      rsp_free_space;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [WSIZE_W-1:0]      csr_window_size = WSIZE_W'(WSIZE_RESET);

   // window model state
   slot_type                lane_state [64] = '{default: SLOT_FREE};
   logic [SEQ_PORT_W-1:0]   base_seq = '0;
   logic [SEQ_PORT_W-1:0]   head_seq = '0;
   int unsigned             ring_base = 0;
   logic [WSIZE_W-1:0]      cur_wsize = WSIZE_W'(WSIZE_RESET);

   window_result_type       pending_results [$];
   window_result_type       oldest;
   int                      errors = 0;
   bit                      quiet = 1'b0;
   int unsigned             stall_left = 0;

   selective_ack_send_window u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_operation         (req_operation),
      .req_sequence_req      (req_sequence_req),
      .req_ack_mask          (req_ack_mask),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_assigned_sequence (rsp_assigned_sequence),
      .rsp_slot_index        (rsp_slot_index),
      .rsp_released_slots    (rsp_released_slots),
      .rsp_base_sequence     (rsp_base_sequence),
      .rsp_free_space        (rsp_free_space),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_window_size       (csr_window_size)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("** selective_ack_send_window: FAILED **");
      $finish;
   end

   // window size saturated into 1..MAX_WINDOW
   function automatic int unsigned win_eff();
      if (cur_wsize == 0) return 1;
      if (cur_wsize > MAX_WINDOW_DEF) return MAX_WINDOW_DEF;
      return 32'(cur_wsize);
   endfunction

   function automatic int seq_delta(logic [SEQ_PORT_W-1:0] a, logic [SEQ_PORT_W-1:0] b);
      logic signed [SEQ_PORT_W-1:0] d;
      d = a - b;
      return int'(d);
   endfunction

   function automatic int unsigned room_left(int unsigned w);
      logic [SEQ_PORT_W-1:0] used;
      used = head_seq - base_seq;
      return (used >= w) ? 0 : w - used;
   endfunction

   // mark one in-window offset acked if it holds data; return its slot bit
   function automatic logic [MASK_W-1:0] mark_acked(int unsigned off, int unsigned w);
      int unsigned pos;
      if (off >= w) return '0;
      pos = ((ring_base % w) + off) % w;
      if (lane_state[pos] != SLOT_DATA) return '0;
      lane_state[pos] = SLOT_ACKED;
      return MASK_W'(1) << pos;
   endfunction

   // free acked slots at the base and advance it
   function automatic bit slide_base(int unsigned w);
      int unsigned pos;
      bit moved;
      moved = 1'b0;
      for (int unsigned n = 0; n < w; n++) begin
         pos = ring_base % w;
         if (lane_state[pos] != SLOT_ACKED) break;
         lane_state[pos] = SLOT_FREE;
         base_seq = base_seq + SEQ_PORT_W'(1);
         ring_base = (pos + 1) % w;
         moved = 1'b1;
      end
      return moved;
   endfunction

   // apply one item to the model and return the result it should produce
   function automatic window_result_type window_predict(op_type op,
                                                        logic [SEQ_PORT_W-1:0] seq,
                                                        logic [MASK_W-1:0] mask);
      window_result_type     res;
      int unsigned           w;
      int unsigned           pos;
      int unsigned           skip;
      logic [SEQ_PORT_W-1:0] used;
      int                    d;
      bit                    gap;
      w = win_eff();
      res.status = STAT_OK;
      res.assigned = '0;
      res.slot = '0;
      res.released = '0;
      case (op)
         OP_ENQUEUE: begin
            if (room_left(w) == 0) begin
               res.status = STAT_FULL;
            end else begin
               used = head_seq - base_seq;
               pos = ((ring_base % w) + used) % w;
               lane_state[pos] = SLOT_DATA;
               res.assigned = head_seq;
               res.slot = SLOT_PORT_W'(pos);
               head_seq = head_seq + SEQ_PORT_W'(1);
            end
         end
         OP_ACK_ONE: begin
            d = seq_delta(seq, base_seq);
            if (d >= int'(w)) begin
               res.status = STAT_INVALID;
            end else if (d < 0) begin
               res.status = STAT_STALE;
            end else begin
               res.released = mark_acked(d, w);
               res.status = slide_base(w) ? STAT_SLID : STAT_OK;
            end
         end
         OP_ACK_MASK: begin
            d = seq_delta(seq, base_seq);
            if (d >= int'(w)) begin
               res.status = STAT_INVALID;
            end else if (d < 0) begin
               // a base behind the window needs every skipped bit set
               skip = -d;
               gap = (skip > MASK_W);
               for (int unsigned i = 0; i < skip && !gap; i++)
                  if (!mask[i]) gap = 1'b1;
               if (gap) begin
                  res.status = STAT_GAP;
               end else begin
                  for (int unsigned i = skip; i < MASK_W; i++)
                     if (mask[i]) res.released |= mark_acked(i - skip, w);
                  res.status = slide_base(w) ? STAT_SLID : STAT_OK;
               end
            end else begin
               // everything below the given base is implied acked
               for (int unsigned i = 0; i < d; i++) res.released |= mark_acked(i, w);
               for (int unsigned i = 0; i < MASK_W; i++)
                  if (mask[i]) res.released |= mark_acked(d + i, w);
               res.status = slide_base(w) ? STAT_SLID : STAT_OK;
            end
         end
         default: begin
            foreach (lane_state[i]) lane_state[i] = SLOT_FREE;
            base_seq = '0;
            head_seq = '0;
            ring_base = 0;
         end
      endcase
      res.base = base_seq;
      res.free = WSIZE_W'(room_left(w));
      return res;
   endfunction

   // random receiver stall bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 10);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic check_field(string name, logic [63:0] exp, logic [63:0] act);
      if (exp !== act) begin
         errors++;
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp, act);
      end
   endtask

   // compare each accepted result with the oldest expected one
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: result with no item pending: expected none, actual status %0d",
                     $time, rsp_status);
         end else begin
            oldest = pending_results.pop_front();
            check_field("status", 64'(oldest.status), 64'(rsp_status));
            check_field("assigned_sequence", 64'(oldest.assigned), 64'(rsp_assigned_sequence));
            check_field("slot_index", 64'(oldest.slot), 64'(rsp_slot_index));
            check_field("released_slots", oldest.released, rsp_released_slots);
            check_field("base_sequence", 64'(oldest.base), 64'(rsp_base_sequence));
            check_field("free_space", 64'(oldest.free), 64'(rsp_free_space));
         end
      end
   end

   // offer one item, hold it until accepted, then record its expected result
   task automatic send_item(op_type op, logic [SEQ_PORT_W-1:0] seq, logic [MASK_W-1:0] mask);
      int unsigned gap;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_sequence_req <= seq;
      req_ack_mask <= mask;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(window_predict(op, seq, mask));
   endtask

   // hold the sender until every expected result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_window(logic [WSIZE_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_window_size <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_wsize = value;
   endtask

   // mostly well-formed traffic around the current base, with some noise
   task automatic random_item();
      int unsigned           w;
      int unsigned           roll;
      int unsigned           k;
      int                    off;
      logic [SEQ_PORT_W-1:0] used;
      logic [SEQ_PORT_W-1:0] seq;
      logic [MASK_W-1:0]     mask;
      op_type                op;
      w = win_eff();
      used = head_seq - base_seq;
      seq = SEQ_PORT_W'($urandom);
      mask = {$urandom, $urandom};
      roll = $urandom_range(0, 99);
      if (roll < 38) begin
         op = OP_ENQUEUE;
      end else if (roll < 62) begin
         op = OP_ACK_ONE;
         case ($urandom_range(0, 5))
            0: ;
            1: begin
               off = int'($urandom_range(0, w + 8)) - 4;
               seq = base_seq + SEQ_PORT_W'(off);
            end
            default: seq = base_seq + SEQ_PORT_W'((used == 0) ? 0
                                                   : $urandom_range(0, used - 1));
         endcase
      end else if (roll < 95) begin
         op = OP_ACK_MASK;
         case ($urandom_range(0, 9))
            0: ;
            1, 2, 3: begin
               // base a few behind: set the skipped bits, sometimes leave a hole
               k = $urandom_range(1, 8);
               seq = base_seq - SEQ_PORT_W'(k);
               mask = mask | (ALL_ONES >> (MASK_W - k));
               if ($urandom_range(0, 3) == 0) mask[$urandom_range(0, k - 1)] = 1'b0;
            end
            4: begin
               k = $urandom_range(62, 66);
               seq = base_seq - SEQ_PORT_W'(k);
               mask = ALL_ONES;
               if ($urandom_range(0, 2) == 0) mask[$urandom_range(0, MASK_W - 1)] = 1'b0;
            end
            default: begin
               seq = base_seq + SEQ_PORT_W'($urandom_range(0, used));
               case ($urandom_range(0, 3))
                  0: mask = '0;
                  1: mask = mask & {$urandom, $urandom} & {$urandom, $urandom};
                  default: ;
               endcase
            end
         endcase
      end else begin
         op = OP_CLEAR;
      end
      send_item(op, seq, mask);
   endtask

   // every operation and each corner case on a four-slot window
   task automatic test_directed();
      write_window(7'd4);
      send_item(OP_ENQUEUE, 16'hFFFF, ALL_ONES);
      send_item(OP_ENQUEUE, 16'h0000, '0);
      send_item(OP_ENQUEUE, 16'h1234, 64'h5A5A);
      send_item(OP_ENQUEUE, 16'h0000, '0);
      // window full
      send_item(OP_ENQUEUE, 16'h0000, '0);
      // out-of-order single ack, then the base ack that slides two
      send_item(OP_ACK_ONE, 16'd1, '0);
      send_item(OP_ACK_ONE, 16'd0, ALL_ONES);
      // stale single ack and one ahead of the window
      send_item(OP_ACK_ONE, 16'd0, '0);
      send_item(OP_ACK_ONE, 16'd6, '0);
      // mask base behind with a skipped bit clear
      send_item(OP_ACK_MASK, 16'hFFFF, '0);
      // all-ones mask reaching past the window
      send_item(OP_ACK_MASK, 16'd2, ALL_ONES);
      send_item(OP_ENQUEUE, 16'h0000, '0);
      send_item(OP_ENQUEUE, 16'h0000, '0);
      send_item(OP_ENQUEUE, 16'h0000, '0);
      // base one behind, skipped bit set, later bit acks mid-window
      send_item(OP_ACK_MASK, 16'd3, 64'h5);
      // base ahead of the window base: implied acks below it
      send_item(OP_ACK_MASK, 16'd6, '0);
      // exactly 64 behind with all ones, then 65 behind
      send_item(OP_ACK_MASK, 16'hFFC6, ALL_ONES);
      send_item(OP_ACK_MASK, 16'hFFC5, ALL_ONES);
      // ack of a free slot
      send_item(OP_ACK_ONE, 16'd7, '0);
      send_item(OP_CLEAR, 16'hFFFF, ALL_ONES);
      send_item(OP_ENQUEUE, 16'h0000, '0);
   endtask

   task automatic test_random_traffic(logic [WSIZE_W-1:0] wsize, int unsigned count);
      write_window(wsize);
      repeat (count / 2) random_item();
      wait_drained();
      repeat (count - count / 2) random_item();
   endtask

   // back-to-back traffic with no idling on either side
   task automatic test_steady_stream();
      quiet = 1'b1;
      write_window(WSIZE_W'($urandom_range(1, 64)));
      repeat (310) random_item();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_traffic(7'd64, 170);
      test_random_traffic(7'd1, 120);
      test_random_traffic(7'd0, 80);
      test_random_traffic(7'd127, 170);
      test_random_traffic(7'd2, 140);
      test_random_traffic(7'd33, 170);
      test_random_traffic(WSIZE_W'($urandom_range(3, 63)), 170);
      test_steady_stream();
      wait_drained();
      if (errors == 0)
         $display("** selective_ack_send_window: PASSED **");
      else
         $display("** selective_ack_send_window: FAILED **");
      $finish;
   end

endmodule

### sim.f
hdl/sasw_pkg.sv
hdl/sasw_slot_lane.sv
hdl/sasw_ring_rotate.sv
hdl/sasw_slide_scan.sv
hdl/selective_ack_send_window.sv
tb/sv/selective_ack_send_window_test.sv
